// ===== rtl/xml_text_escaper_defines.svh =====
// Assertion macros used by the escaper's top level.
`ifndef XML_TEXT_ESCAPER_DEFINES_SVH
`define XML_TEXT_ESCAPER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle in reset
`define XTE_ASSERT_IMPLIES(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("xml_text_escaper: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, idle in reset
`define XTE_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("xml_text_escaper: next-cycle check failed");

`endif

// ===== rtl/xte_pkg.sv =====
// Types, constants and entity tables of the XML text escaper.
package xte_pkg;

  // Default depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } out_t;

  // Replacement class of one input byte
  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_APOS,
    KIND_REPL
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] text_byte;
    logic       final_byte;
  } cmd_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // Run length of each class, one to six bytes
  function automatic logic [2:0] run_len(kind_e kind);
    logic [2:0] len;
    case (kind)
      KIND_AMP:  len = 3'd5;
      KIND_LT:   len = 3'd4;
      KIND_GT:   len = 3'd4;
      KIND_QUOT: len = 3'd6;
      KIND_APOS: len = 3'd6;
      KIND_REPL: len = 3'd3;
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  // Byte at position idx of a run; a plain pass gives the raw byte
  function automatic logic [7:0] seq_byte(kind_e kind, logic [2:0] idx, logic [7:0] raw);
    logic [7:0] b;
    b = raw;
    case (kind)
      KIND_AMP: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h61;
          3'd2:    b = 8'h6D;
          3'd3:    b = 8'h70;
          default: b = 8'h3B;
        endcase
      end
      KIND_LT: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h6C;
          3'd2:    b = 8'h74;
          default: b = 8'h3B;
        endcase
      end
      KIND_GT: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h67;
          3'd2:    b = 8'h74;
          default: b = 8'h3B;
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h71;
          3'd2:    b = 8'h75;
          3'd3:    b = 8'h6F;
          3'd4:    b = 8'h74;
          default: b = 8'h3B;
        endcase
      end
      KIND_APOS: begin
        case (idx)
          3'd0:    b = 8'h26;
          3'd1:    b = 8'h61;
          3'd2:    b = 8'h70;
          3'd3:    b = 8'h6F;
          3'd4:    b = 8'h73;
          default: b = 8'h3B;
        endcase
      end
      KIND_REPL: begin
        case (idx)
          3'd0:    b = 8'hEF;
          3'd1:    b = 8'hBF;
          default: b = 8'hBD;
        endcase
      end
      default: b = raw;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/xte_front.sv =====
// Front end: accepts input transactions and classifies each byte.
module xte_front (
  input  logic          in_valid_i,
  input  xte_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  input  xte_pkg::qstat_t qstat_i,
  output logic          push_o,
  output xte_pkg::cmd_t push_cmd_o
);
  import xte_pkg::*;

  kind_e kind;

  // Classify the byte into its replacement class
  always_comb begin
    case (in_data_i.text_byte) inside
      8'h26:                      kind = KIND_AMP;
      8'h3C:                      kind = KIND_LT;
      8'h3E:                      kind = KIND_GT;
      8'h22:                      kind = KIND_QUOT;
      8'h27:                      kind = KIND_APOS;
      8'h09, 8'h0A, 8'h0D:        kind = KIND_PASS;
      [8'h00:8'h1F]:              kind = KIND_REPL;
      default:                    kind = KIND_PASS;
    endcase
  end

  // Push when the queue has room
  assign in_stall_o            = qstat_i.full;
  assign push_o                = in_valid_i & ~qstat_i.full;
  assign push_cmd_o.kind       = kind;
  assign push_cmd_o.text_byte  = in_data_i.text_byte;
  assign push_cmd_o.final_byte = in_data_i.final_byte;

endmodule

// ===== rtl/xte_queue.sv =====
// Short command queue between the classifier and the emitter.
module xte_queue #(
  parameter int unsigned Depth = xte_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  xte_pkg::cmd_t   push_cmd_i,
  input  logic            pop_i,
  output xte_pkg::cmd_t   head_o,
  output xte_pkg::qstat_t qstat_o
);
  import xte_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.full  = (cnt_q == FullCnt);

endmodule

// ===== rtl/xte_back.sv =====
// Back end: walks each queued command through its run of output bytes.
module xte_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  xte_pkg::cmd_t   head_i,
  input  xte_pkg::qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  output xte_pkg::out_t   out_data_o,
  input  logic            out_stall_i
);
  import xte_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic       load;
  logic       last;

  // Output register may take a new byte when empty or being taken
  assign load  = ~out_valid_q | ~out_stall_i;
  assign last  = (idx_q == run_len(head_i.kind) - 3'd1);
  assign pop_o = load & ~qstat_i.empty & last;

  // Next byte of the current run
  always_comb begin
    idx_d            = idx_q;
    out_valid_d      = out_valid_q;
    out_d.out_byte   = seq_byte(head_i.kind, idx_q, head_i.text_byte);
    out_d.run_end    = last;
    out_d.text_end   = last & head_i.final_byte;
    if (load) begin
      out_valid_d = ~qstat_i.empty;
      if (!qstat_i.empty) begin
        idx_d = last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/xml_text_escaper.sv =====
// Top level of the XML text escaper: classifier, command queue and emitter.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (text_byte, final_byte)
//   out      output     out_valid_o / out_stall_i  out_data_o (out_byte, run_end, text_end)
//
// One output byte leaves per cycle while out_stall_i is low; an input byte with a run of n bytes
// gives n output bytes (one for plain bytes, up to six for quot and apos).
// Input is stalled only while the command queue is full; it is Depth entries.
// The first output byte passes through the queue entry and then the output register before it is presented.
// Reset clears the queue pointers and fill count, run index and output valid; nothing else.
module xml_text_escaper #(
  parameter int unsigned QueueDepth = xte_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  xte_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output xte_pkg::out_t out_data_o,
  input  logic          out_stall_i
);
  import xte_pkg::*;

`include "xml_text_escaper_defines.svh"

  logic   push;
  logic   pop;
  cmd_t   push_cmd;
  cmd_t   head;
  qstat_t qstat;

  xte_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .qstat_i    (qstat),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  xte_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .qstat_o    (qstat)
  );

  xte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  // A queue cannot be empty and full at once
  `XTE_ASSERT_IMPLIES(a_queue_state, qstat.empty, !qstat.full)
  // End of text only ever falls on the end of a run
  `XTE_ASSERT_IMPLIES(a_text_end_run, out_valid_o && out_data_o.text_end, out_data_o.run_end)
  // A run continues without a gap once a mid-run byte is taken
  `XTE_ASSERT_NEXT(a_run_contig, out_valid_o && !out_stall_i && !out_data_o.run_end, out_valid_o)

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the XML text escaper.
`timescale 1ns / 1ps

module tb;
  import xte_pkg::*;

  // Characters that take an entity, and the control-byte bounds
  localparam logic [7:0] CHR_AMP    = 8'h26;
  localparam logic [7:0] CHR_LT     = 8'h3C;
  localparam logic [7:0] CHR_GT     = 8'h3E;
  localparam logic [7:0] CHR_QUOT   = 8'h22;
  localparam logic [7:0] CHR_APOS   = 8'h27;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // Replacement runs, first byte in the most significant position
  localparam logic [47:0] ENT_AMP  = {8'h00, "&amp;"};
  localparam logic [47:0] ENT_LT   = {16'h0000, "&lt;"};
  localparam logic [47:0] ENT_GT   = {16'h0000, "&gt;"};
  localparam logic [47:0] ENT_QUOT = "&quot;";
  localparam logic [47:0] ENT_APOS = "&apos;";
  localparam logic [47:0] REPL_CHR = 48'hEFBFBD;

  localparam int CLK_HALF   = 5;
  localparam int RESET_CYC  = 9;
  localparam int SETTLE_CYC = 10;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_data  = '0;
  logic in_stall;
  logic out_valid;
  out_t out_data;
  logic out_stall = 1'b0;

  // Idle control for each side
  bit   in_idle_en  = 1'b0;
  bit   out_idle_en = 1'b0;
  int   out_hold_left = 0;
  int   error_count   = 0;

  // Escaped bytes still owed by the block, oldest first
  out_t escaped_q[$];

  xml_text_escaper u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_data_i  (in_data),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_data_o (out_data),
    .out_stall_i(out_stall)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic kind_e classify(logic [7:0] b);
    case (b)
      CHR_AMP:  return KIND_AMP;
      CHR_LT:   return KIND_LT;
      CHR_GT:   return KIND_GT;
      CHR_QUOT: return KIND_QUOT;
      CHR_APOS: return KIND_APOS;
      default: begin
        if (b < CTRL_LIMIT && b != CHR_TAB && b != CHR_LF && b != CHR_CR) begin
          return KIND_REPL;
        end
        return KIND_PASS;
      end
    endcase
  endfunction

  // Queue up the escaped run for one accepted text byte
  function automatic void predict_escape(in_t item);
    logic [47:0] seq;
    int          len;
    out_t        res;
    case (classify(item.text_byte))
      KIND_AMP: begin
        seq = ENT_AMP;  len = 5;
      end
      KIND_LT: begin
        seq = ENT_LT;   len = 4;
      end
      KIND_GT: begin
        seq = ENT_GT;   len = 4;
      end
      KIND_QUOT: begin
        seq = ENT_QUOT; len = 6;
      end
      KIND_APOS: begin
        seq = ENT_APOS; len = 6;
      end
      KIND_REPL: begin
        seq = REPL_CHR; len = 3;
      end
      default: begin
        seq = {40'd0, item.text_byte}; len = 1;
      end
    endcase
    for (int k = 0; k < len; k++) begin
      res.out_byte = seq[8 * (len - 1 - k) +: 8];
      res.run_end  = (k == len - 1);
      res.text_end = (k == len - 1) && item.final_byte;
      escaped_q.push_back(res);
    end
  endfunction

  // Send one text byte; valid is left high so the next one can follow at once
  task automatic send_text_byte(logic [7:0] b, logic fin);
    int gap;
    gap = (in_idle_en && $urandom_range(0, 9) < 4) ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_byte: b, final_byte: fin};
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_escape('{text_byte: b, final_byte: fin});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_entity_char();
    case ($urandom_range(0, 4))
      0:       return CHR_AMP;
      1:       return CHR_LT;
      2:       return CHR_GT;
      3:       return CHR_QUOT;
      default: return CHR_APOS;
    endcase
  endfunction

  // Text bytes weighted towards the interesting classes
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return pick_entity_char();
    end
    if (r == 3) begin
      return 8'($urandom_range(0, 31));
    end
    if (r == 4) begin
      case ($urandom_range(0, 2))
        0:       return CHR_TAB;
        1:       return CHR_LF;
        default: return CHR_CR;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Boundaries of the control range, the allowed controls and the byte extremes
  task automatic test_boundary_bytes();
    logic [7:0] edge_bytes [13];
    edge_bytes = '{8'h00, 8'h08, CHR_TAB, CHR_LF, 8'h0B, 8'h0C, CHR_CR, 8'h0E,
                   8'h1F, 8'h20, 8'h7F, 8'h80, 8'hFF};
    foreach (edge_bytes[i]) send_text_byte(edge_bytes[i], i == 12);
  endtask

  // Every entity, then every entity as a one-byte text back to back
  task automatic test_entities();
    logic [7:0] ents [5];
    ents = '{CHR_AMP, CHR_LT, CHR_GT, CHR_QUOT, CHR_APOS};
    foreach (ents[i]) send_text_byte(ents[i], 1'b0);
    foreach (ents[i]) send_text_byte(ents[i], 1'b1);
  endtask

  // Fill the queue behind a randomly stalled output, wait until all is out, then send a short quot text
  task automatic test_drain_pause();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    for (int i = 0; i < 8; i++) send_text_byte(pick_entity_char(), i == 7);
    wait_drained();
    for (int i = 0; i < 4; i++) send_text_byte(CHR_QUOT, i == 3);
  endtask

  // Random texts of random length
  task automatic test_random_text(int n_bytes, bit in_idle, bit out_idle);
    int chunk_len;
    int pos;
    in_idle_en  = in_idle;
    out_idle_en = out_idle;
    chunk_len = 0;
    pos       = 0;
    for (int i = 0; i < n_bytes; i++) begin
      if (pos == chunk_len) begin
        chunk_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 14);
        pos       = 0;
      end
      send_text_byte(pick_text_byte(), pos == chunk_len - 1);
      pos++;
    end
  endtask

  // Output stall pattern
  always @(posedge clk) begin
    if (out_hold_left != 0) begin
      out_hold_left <= out_hold_left - 1;
    end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
      out_stall     <= 1'b1;
      out_hold_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every output transaction with the oldest expected byte
  always @(posedge clk) begin
    out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (escaped_q.size() == 0) begin
        $error("unexpected output byte %h", out_data.out_byte);
        error_count++;
      end else begin
        exp_res = escaped_q.pop_front();
        if (out_data.out_byte !== exp_res.out_byte) begin
          $error("out_byte: expected %h, got %h", exp_res.out_byte, out_data.out_byte);
          error_count++;
        end
        if (out_data.run_end !== exp_res.run_end) begin
          $error("run_end: expected %b, got %b", exp_res.run_end, out_data.run_end);
          error_count++;
        end
        if (out_data.text_end !== exp_res.text_end) begin
          $error("text_end: expected %b, got %b", exp_res.text_end, out_data.text_end);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_boundary_bytes();
    test_entities();
    test_drain_pause();
    test_random_text(90, 1'b1, 1'b1);
    test_random_text(60, 1'b0, 1'b0);
    test_random_text(60, 1'b0, 1'b1);
    test_random_text(70, 1'b1, 1'b0);

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (escaped_q.size() != 0) begin
      $error("%0d output bytes never arrived", escaped_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
